// ===== sv/sfha_pkg.sv =====
`default_nettype none
package sfha_pkg;

  // Heap geometry and free-list organization.
  localparam int unsigned HeapBytes  = 65536;
  localparam int unsigned NumClasses = 16;
  localparam int unsigned HeapWords  = HeapBytes / 4;
  localparam int unsigned AddrW      = $clog2(HeapBytes);
  localparam int unsigned WordAw     = AddrW - 2;
  localparam int unsigned BrkW       = AddrW + 1;
  localparam int unsigned StepW      = $clog2(HeapWords) + 1;
  localparam int unsigned ClsW       = $clog2(NumClasses);

  // Fixed field widths and tag constants.
  localparam int unsigned ChunkW     = 17;
  localparam logic [ChunkW-1:0] ChunkReset = ChunkW'(1 << 12);
  localparam logic [31:0] SizeMask  = ~32'h7;
  localparam logic [31:0] AllocFlag = 32'h1;
  localparam logic [31:0] MinBlock  = 32'd16;

  typedef enum logic [1:0] {
    ReqInit  = 2'd0,
    ReqAlloc = 2'd1,
    ReqFree  = 2'd2,
    ReqRsvd  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    StatDone  = 2'd0,
    StatZero  = 2'd1,
    StatNoMem = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] request_size;
    logic [15:0] block_address;
  } req_t;

  typedef struct packed {
    logic [15:0] result_address;
    logic [1:0]  status;
  } rsp_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic        sub;
  } alu_op_t;

  typedef struct packed {
    logic        re;
    logic        we;
    logic [31:0] addr;
    logic [31:0] wdata;
  } mem_req_t;

  // Smallest class c with size <= 2^c; the last class takes the rest.
  function automatic logic [ClsW-1:0] class_of(input logic [31:0] size);
    logic [ClsW-1:0] c;
    c = '0;
    for (int i = 0; i < NumClasses - 1; i++) begin
      if ({1'b0, size} > (33'd1 << i)) c = ClsW'(i + 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== sv/sfha_ifs.sv =====
`default_nettype none
// Request channel.
interface sfha_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [15:0] request_size;
  logic [15:0] block_address;
  modport source (output valid, req_type, request_size, block_address, input ready);
  modport sink   (input valid, req_type, request_size, block_address, output ready);
endinterface

// Response channel.
interface sfha_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] result_address;
  logic [1:0]  status;
  modport source (output valid, result_address, status, input ready);
  modport sink   (input valid, result_address, status, output ready);
endinterface

// Configuration write channel for the chunk size register.
interface sfha_cfg_if;
  logic        valid;
  logic        ready;
  logic [16:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== sv/sfha_alu.sv =====
`default_nettype none
module sfha_alu (
  input  sfha_pkg::alu_op_t op_i,
  output logic [32:0]       res_o
);

  // Shared adder for the sequencer's address, size and compare steps; bit 32 is carry (a >= b on subtract).
  assign res_o = {1'b0, op_i.a} + {1'b0, (op_i.sub ? ~op_i.b : op_i.b)} + 33'(op_i.sub);

endmodule
`default_nettype wire

// ===== sv/sfha_heap_mem.sv =====
`default_nettype none
module sfha_heap_mem (
  input  logic               clk_i,
  input  sfha_pkg::mem_req_t req_i,
  output logic [31:0]        rdata_o
);

  logic [31:0] mem_q [sfha_pkg::HeapWords];
  logic [31:0] data_q;
  logic        oor_q;
  logic        in_range;
  logic [sfha_pkg::WordAw-1:0] idx;

  // Byte offsets outside the heap read as zero and drop writes.
  assign in_range = (req_i.addr[31:sfha_pkg::AddrW] == '0);
  assign idx      = req_i.addr[sfha_pkg::AddrW-1:2];

  always_ff @(posedge clk_i) begin
    if (req_i.we && in_range) begin
      mem_q[idx] <= req_i.wdata;
    end
    if (req_i.re) begin
      data_q <= mem_q[idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      oor_q <= !in_range;
    end
  end

  assign rdata_o = oor_q ? 32'd0 : data_q;

endmodule
`default_nettype wire

// ===== sv/sfha_seq.sv =====
`default_nettype none
module sfha_seq (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  sfha_pkg::req_t                  req_i,
  input  logic [sfha_pkg::ChunkW-1:0]     chunk_i,
  input  logic                            out_free_i,
  output logic                            idle_o,
  output logic                            done_o,
  output sfha_pkg::rsp_t                  rsp_o,
  output sfha_pkg::alu_op_t               alu_op_o,
  input  logic [32:0]                     alu_res_i,
  output sfha_pkg::mem_req_t              mem_req_o,
  input  logic [31:0]                     mem_rdata_i
);

  typedef enum logic [6:0] {
    S_IDLE, S_INIT0, S_INIT1, S_INIT2, S_INIT3,
    S_GROW0, S_GROW1, S_GROW2, S_GROW3, S_GROW4, S_GRET,
    S_MG0, S_MG1, S_MG2, S_MG3, S_MG4,
    S_MA0, S_MA1, S_MA2, S_MA3, S_MA4,
    S_MB0, S_MB1, S_MB2, S_MB3, S_MB4, S_MB5,
    S_MC0, S_MC1, S_MC2, S_MC3, S_MC4, S_MC5, S_MC6, S_MRET,
    S_UL0, S_UL1, S_UL2, S_UL3, S_UL4, S_UL5, S_UL6, S_URET,
    S_PU0, S_PU1, S_PU2, S_PU3, S_PU4, S_PU5, S_PRET,
    S_FIND0, S_FD1, S_FD2, S_FD3, S_FD3B, S_FD4,
    S_CV0, S_CV0B, S_CV1, S_CV2, S_CV3, S_CV4, S_CV5, S_CV6, S_CV7,
    S_CN0, S_CN1, S_CN2,
    S_FR0, S_FR1, S_FR2, S_FR3, S_FR4, S_FR5,
    S_DONE
  } state_e;

  typedef enum logic {GR_INIT, GR_ALLOC} ret_grow_e;
  typedef enum logic {MR_GROW, MR_FREE} ret_merge_e;
  typedef enum logic {RP_MERGE, RP_CARVE} ret_push_e;
  typedef enum logic [2:0] {RU_MA, RU_MB, RU_MC1, RU_MC2, RU_CARVE} ret_unlink_e;

  state_e      st_q;
  ret_grow_e   ret_grow_q;
  ret_merge_e  ret_merge_q;
  ret_push_e   ret_push_q;
  ret_unlink_e ret_unlink_q;

  logic [31:0] bp_q, sz_q, pf_q, nb_q, pb_q, end_q, t_q, arg_q, lp_q, ln_q, walk_q;
  logic [31:0] heads_q [sfha_pkg::NumClasses];
  logic [sfha_pkg::ChunkW-1:0] asize_q, gb_q;
  logic [sfha_pkg::ClsW-1:0]   cls_q;
  logic [sfha_pkg::ClsW:0]     fcls_q;
  logic [sfha_pkg::StepW-1:0]  steps_q;
  logic [sfha_pkg::BrkW-1:0]   brk_q;
  logic [15:0] res_q;
  logic [1:0]  stat_q;

  logic [31:0] rsz;
  logic [sfha_pkg::ChunkW:0] gsz;
  logic [sfha_pkg::ChunkW-1:0] asize_calc;
  logic free_ok;

  assign rsz = mem_rdata_i & sfha_pkg::SizeMask;

  // Growth is rounded to the nearest multiple of eight bytes, halves rounded up.
  assign gsz = {(sfha_pkg::ChunkW-2)'(gb_q[sfha_pkg::ChunkW-1:3])
                + (sfha_pkg::ChunkW-2)'(gb_q[2]), 3'b000};

  // Adjusted block size: header, footer and eight-byte alignment.
  assign asize_calc = (req_i.request_size <= 16'd8) ? sfha_pkg::ChunkW'(16) :
                      ((sfha_pkg::ChunkW'(req_i.request_size) + sfha_pkg::ChunkW'(15))
                       & ~sfha_pkg::ChunkW'(7));

  // A free is only taken for an aligned payload offset inside the heap.
  assign free_ok = (brk_q != '0) && (req_i.block_address[2:0] == 3'd0) &&
                   (req_i.block_address >= 16'd16) &&
                   (sfha_pkg::BrkW'(req_i.block_address) < brk_q);

  assign idle_o = (st_q == S_IDLE);
  assign done_o = (st_q == S_DONE) && out_free_i;
  assign rsp_o  = '{result_address: res_q, status: stat_q};

  // Operand and memory selection for the shared adder in each step.
  always_comb begin
    alu_op_o        = '{a: 32'd0, b: 32'd0, sub: 1'b0};
    mem_req_o.re    = 1'b0;
    mem_req_o.we    = 1'b0;
    mem_req_o.wdata = 32'd0;
    case (st_q)
      S_INIT0: begin alu_op_o.a = 32'd0;  mem_req_o.we = 1'b1; end
      S_INIT1: begin alu_op_o.a = 32'd4;  mem_req_o.we = 1'b1; mem_req_o.wdata = 32'd9; end
      S_INIT2: begin alu_op_o.a = 32'd8;  mem_req_o.we = 1'b1; mem_req_o.wdata = 32'd9; end
      S_INIT3: begin
        alu_op_o.a = 32'd12; mem_req_o.we = 1'b1; mem_req_o.wdata = sfha_pkg::AllocFlag;
      end
      S_GROW0: begin alu_op_o.a = 32'(brk_q); alu_op_o.b = 32'(gsz); end
      S_GROW1: begin
        alu_op_o = '{a: bp_q, b: 32'd4, sub: 1'b1}; mem_req_o.we = 1'b1; mem_req_o.wdata = sz_q;
      end
      S_GROW2: begin alu_op_o.a = bp_q; alu_op_o.b = sz_q; end
      S_GROW3: begin
        alu_op_o = '{a: end_q, b: 32'd8, sub: 1'b1}; mem_req_o.we = 1'b1; mem_req_o.wdata = sz_q;
      end
      S_GROW4: begin
        alu_op_o = '{a: end_q, b: 32'd4, sub: 1'b1}; mem_req_o.we = 1'b1;
        mem_req_o.wdata = sfha_pkg::AllocFlag;
      end
      S_MG0:   begin alu_op_o = '{a: bp_q, b: 32'd4, sub: 1'b1}; mem_req_o.re = 1'b1; end
      S_MG1:   begin alu_op_o = '{a: bp_q, b: 32'd8, sub: 1'b1}; mem_req_o.re = 1'b1; end
      S_MG2:   begin alu_op_o.a = bp_q; alu_op_o.b = sz_q; end
      S_MG3:   begin alu_op_o = '{a: nb_q, b: 32'd4, sub: 1'b1}; mem_req_o.re = 1'b1; end
      S_MG4:   alu_op_o = '{a: bp_q, b: pf_q & sfha_pkg::SizeMask, sub: 1'b1};
      S_MA0:   begin alu_op_o = '{a: nb_q, b: 32'd4, sub: 1'b1}; mem_req_o.re = 1'b1; end
      S_MA1:   begin alu_op_o.a = sz_q; alu_op_o.b = rsz; end
      S_MA2: begin
        alu_op_o = '{a: bp_q, b: 32'd4, sub: 1'b1}; mem_req_o.we = 1'b1; mem_req_o.wdata = sz_q;
      end
      S_MA3:   begin alu_op_o.a = bp_q; alu_op_o.b = sz_q; end
      S_MA4: begin
        alu_op_o = '{a: end_q, b: 32'd8, sub: 1'b1}; mem_req_o.we = 1'b1; mem_req_o.wdata = sz_q;
      end
      S_MB0:   begin alu_op_o = '{a: pb_q, b: 32'd4, sub: 1'b1}; mem_req_o.re = 1'b1; end
      S_MB1:   begin alu_op_o.a = sz_q; alu_op_o.b = rsz; end
      S_MB2: begin
        alu_op_o = '{a: nb_q, b: 32'd8, sub: 1'b1}; mem_req_o.we = 1'b1; mem_req_o.wdata = t_q;
      end
      S_MB3:   begin alu_op_o = '{a: pb_q, b: 32'd4, sub: 1'b1}; mem_req_o.re = 1'b1; end
      S_MB4:   begin alu_op_o.a = sz_q; alu_op_o.b = rsz; end
      S_MB5: begin
        alu_op_o = '{a: pb_q, b: 32'd4, sub: 1'b1}; mem_req_o.we = 1'b1; mem_req_o.wdata = sz_q;
      end
      S_MC0:   begin alu_op_o = '{a: nb_q, b: 32'd4, sub: 1'b1}; mem_req_o.re = 1'b1; end
      S_MC1:   begin alu_op_o = '{a: pb_q, b: 32'd4, sub: 1'b1}; mem_req_o.re = 1'b1; end
      S_MC2:   begin alu_op_o.a = sz_q; alu_op_o.b = rsz; end
      S_MC3:   begin alu_op_o.a = sz_q; alu_op_o.b = t_q; end
      S_MC4: begin
        alu_op_o = '{a: pb_q, b: 32'd4, sub: 1'b1}; mem_req_o.we = 1'b1; mem_req_o.wdata = sz_q;
      end
      S_MC5:   begin alu_op_o.a = nb_q; alu_op_o.b = t_q; end
      S_MC6: begin
        alu_op_o = '{a: end_q, b: 32'd8, sub: 1'b1}; mem_req_o.we = 1'b1; mem_req_o.wdata = sz_q;
      end
      S_UL0:   begin alu_op_o = '{a: arg_q, b: 32'd4, sub: 1'b1}; mem_req_o.re = 1'b1; end
      S_UL1:   begin alu_op_o.a = arg_q; mem_req_o.re = 1'b1; end
      S_UL2:   begin alu_op_o.a = arg_q; alu_op_o.b = 32'd4; mem_req_o.re = 1'b1; end
      S_UL4:   begin alu_op_o.a = ln_q; mem_req_o.we = 1'b1; end
      S_UL5: begin
        alu_op_o.a = lp_q; alu_op_o.b = 32'd4; mem_req_o.we = 1'b1; mem_req_o.wdata = ln_q;
      end
      S_UL6:   begin alu_op_o.a = ln_q; mem_req_o.we = 1'b1; mem_req_o.wdata = lp_q; end
      S_PU0:   begin alu_op_o = '{a: arg_q, b: 32'd4, sub: 1'b1}; mem_req_o.re = 1'b1; end
      S_PU2:   begin alu_op_o.a = arg_q; mem_req_o.we = 1'b1; end
      S_PU3: begin
        alu_op_o.a = arg_q; alu_op_o.b = 32'd4; mem_req_o.we = 1'b1; mem_req_o.wdata = lp_q;
      end
      S_PU4:   begin alu_op_o.a = lp_q; mem_req_o.we = 1'b1; mem_req_o.wdata = arg_q; end
      S_FD2:   begin alu_op_o = '{a: walk_q, b: 32'd4, sub: 1'b1}; mem_req_o.re = 1'b1; end
      S_FD3:   alu_op_o = '{a: rsz, b: 32'(asize_q), sub: 1'b1};
      S_FD3B:  begin alu_op_o.a = walk_q; alu_op_o.b = 32'd4; mem_req_o.re = 1'b1; end
      S_CV0:   begin alu_op_o = '{a: bp_q, b: 32'd4, sub: 1'b1}; mem_req_o.re = 1'b1; end
      S_CV1:   alu_op_o = '{a: sz_q, b: 32'(asize_q), sub: 1'b1};
      S_CV2: begin
        alu_op_o = '{a: bp_q, b: 32'd4, sub: 1'b1}; mem_req_o.we = 1'b1;
        mem_req_o.wdata = 32'(asize_q) | sfha_pkg::AllocFlag;
      end
      S_CV3:   begin alu_op_o.a = bp_q; alu_op_o.b = 32'(asize_q); end
      S_CV4: begin
        alu_op_o = '{a: end_q, b: 32'd8, sub: 1'b1}; mem_req_o.we = 1'b1;
        mem_req_o.wdata = 32'(asize_q) | sfha_pkg::AllocFlag;
      end
      S_CV5: begin
        alu_op_o = '{a: end_q, b: 32'd4, sub: 1'b1}; mem_req_o.we = 1'b1; mem_req_o.wdata = t_q;
      end
      S_CV6:   begin alu_op_o.a = end_q; alu_op_o.b = t_q; end
      S_CV7: begin
        alu_op_o = '{a: nb_q, b: 32'd8, sub: 1'b1}; mem_req_o.we = 1'b1; mem_req_o.wdata = t_q;
      end
      S_CN0:   begin alu_op_o.a = bp_q; alu_op_o.b = sz_q; end
      S_CN1: begin
        alu_op_o = '{a: bp_q, b: 32'd4, sub: 1'b1}; mem_req_o.we = 1'b1;
        mem_req_o.wdata = sz_q | sfha_pkg::AllocFlag;
      end
      S_CN2: begin
        alu_op_o = '{a: end_q, b: 32'd8, sub: 1'b1}; mem_req_o.we = 1'b1;
        mem_req_o.wdata = sz_q | sfha_pkg::AllocFlag;
      end
      S_FR0:   begin alu_op_o = '{a: bp_q, b: 32'd4, sub: 1'b1}; mem_req_o.re = 1'b1; end
      S_FR1:   begin alu_op_o.a = bp_q; alu_op_o.b = rsz; end
      S_FR2:   begin alu_op_o = '{a: end_q, b: 32'd8, sub: 1'b1}; mem_req_o.re = 1'b1; end
      S_FR4: begin
        alu_op_o = '{a: bp_q, b: 32'd4, sub: 1'b1}; mem_req_o.we = 1'b1; mem_req_o.wdata = sz_q;
      end
      S_FR5: begin
        alu_op_o = '{a: end_q, b: 32'd8, sub: 1'b1}; mem_req_o.we = 1'b1; mem_req_o.wdata = sz_q;
      end
      default: ;
    endcase
  end

  assign mem_req_o.addr = alu_res_i[31:0];

  // Sequencer: state, subroutine return points and working registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= S_IDLE;
      ret_grow_q   <= GR_INIT;
      ret_merge_q  <= MR_GROW;
      ret_push_q   <= RP_MERGE;
      ret_unlink_q <= RU_MA;
      brk_q        <= '0;
      fcls_q       <= '0;
      steps_q      <= '0;
      for (int i = 0; i < sfha_pkg::NumClasses; i++) heads_q[i] <= 32'd0;
    end else begin
      case (st_q)
        S_IDLE: begin
          if (start_i) begin
            res_q   <= 16'd0;
            stat_q  <= sfha_pkg::StatDone;
            bp_q    <= 32'(req_i.block_address);
            steps_q <= '0;
            case (req_i.req_type)
              sfha_pkg::ReqInit: st_q <= S_INIT0;
              sfha_pkg::ReqAlloc: begin
                if (req_i.request_size == 16'd0) begin
                  stat_q <= sfha_pkg::StatZero;
                  st_q   <= S_DONE;
                end else if (brk_q == '0) begin
                  stat_q <= sfha_pkg::StatNoMem;
                  st_q   <= S_DONE;
                end else begin
                  asize_q <= asize_calc;
                  st_q    <= S_FIND0;
                end
              end
              sfha_pkg::ReqFree: st_q <= free_ok ? S_FR0 : S_DONE;
              default: st_q <= S_DONE;
            endcase
          end
        end

        // Heap initialization: prologue, epilogue, then the first growth.
        S_INIT0: begin
          for (int i = 0; i < sfha_pkg::NumClasses; i++) heads_q[i] <= 32'd0;
          st_q <= S_INIT1;
        end
        S_INIT1: st_q <= S_INIT2;
        S_INIT2: st_q <= S_INIT3;
        S_INIT3: begin
          brk_q      <= sfha_pkg::BrkW'(16);
          gb_q       <= (chunk_i < sfha_pkg::ChunkW'(16)) ? sfha_pkg::ChunkW'(16) : chunk_i;
          ret_grow_q <= GR_INIT;
          st_q       <= S_GROW0;
        end

        // Break extension.
        S_GROW0: begin
          if (alu_res_i > 33'(sfha_pkg::HeapBytes)) begin
            bp_q <= 32'd0;
            st_q <= S_GRET;
          end else begin
            bp_q  <= 32'(brk_q);
            sz_q  <= 32'(gsz);
            brk_q <= alu_res_i[sfha_pkg::BrkW-1:0];
            st_q  <= S_GROW1;
          end
        end
        S_GROW1: st_q <= S_GROW2;
        S_GROW2: begin end_q <= alu_res_i[31:0]; st_q <= S_GROW3; end
        S_GROW3: st_q <= S_GROW4;
        S_GROW4: begin ret_merge_q <= MR_GROW; st_q <= S_MG0; end
        S_GRET: begin
          if (ret_grow_q == GR_INIT) begin
            stat_q <= (bp_q == 32'd0) ? sfha_pkg::StatNoMem : sfha_pkg::StatDone;
            st_q   <= S_DONE;
          end else if (bp_q == 32'd0) begin
            stat_q <= sfha_pkg::StatNoMem;
            st_q   <= S_DONE;
          end else begin
            st_q <= S_CV0;
          end
        end

        // Coalescing with the neighboring blocks.
        S_MG0: st_q <= S_MG1;
        S_MG1: begin sz_q <= rsz; st_q <= S_MG2; end
        S_MG2: begin pf_q <= mem_rdata_i; nb_q <= alu_res_i[31:0]; st_q <= S_MG3; end
        S_MG3: st_q <= S_MG4;
        S_MG4: begin
          pb_q <= alu_res_i[31:0];
          if (pf_q[0] && mem_rdata_i[0]) begin
            arg_q <= bp_q; ret_push_q <= RP_MERGE; st_q <= S_PU0;
          end else if (pf_q[0]) begin
            arg_q <= nb_q; ret_unlink_q <= RU_MA; st_q <= S_UL0;
          end else if (mem_rdata_i[0]) begin
            arg_q <= alu_res_i[31:0]; ret_unlink_q <= RU_MB; st_q <= S_UL0;
          end else begin
            arg_q <= alu_res_i[31:0]; ret_unlink_q <= RU_MC1; st_q <= S_UL0;
          end
        end
        S_MA0: st_q <= S_MA1;
        S_MA1: begin sz_q <= alu_res_i[31:0]; st_q <= S_MA2; end
        S_MA2: st_q <= S_MA3;
        S_MA3: begin end_q <= alu_res_i[31:0]; st_q <= S_MA4; end
        S_MA4: begin arg_q <= bp_q; ret_push_q <= RP_MERGE; st_q <= S_PU0; end
        S_MB0: st_q <= S_MB1;
        S_MB1: begin t_q <= alu_res_i[31:0]; st_q <= S_MB2; end
        S_MB2: st_q <= S_MB3;
        S_MB3: st_q <= S_MB4;
        S_MB4: begin sz_q <= alu_res_i[31:0]; st_q <= S_MB5; end
        S_MB5: begin
          bp_q <= pb_q; arg_q <= pb_q; ret_push_q <= RP_MERGE; st_q <= S_PU0;
        end
        S_MC0: st_q <= S_MC1;
        S_MC1: begin t_q <= rsz; st_q <= S_MC2; end
        S_MC2: begin sz_q <= alu_res_i[31:0]; st_q <= S_MC3; end
        S_MC3: begin sz_q <= alu_res_i[31:0]; st_q <= S_MC4; end
        S_MC4: st_q <= S_MC5;
        S_MC5: begin end_q <= alu_res_i[31:0]; st_q <= S_MC6; end
        S_MC6: begin
          bp_q <= pb_q; arg_q <= pb_q; ret_push_q <= RP_MERGE; st_q <= S_PU0;
        end
        S_MRET: st_q <= (ret_merge_q == MR_GROW) ? S_GRET : S_DONE;

        // Removal of a block from its class list.
        S_UL0: st_q <= S_UL1;
        S_UL1: begin cls_q <= sfha_pkg::class_of(rsz); st_q <= S_UL2; end
        S_UL2: begin lp_q <= mem_rdata_i; st_q <= S_UL3; end
        S_UL3: begin
          ln_q <= mem_rdata_i;
          if (heads_q[cls_q] == arg_q) begin
            heads_q[cls_q] <= mem_rdata_i;
            st_q <= (mem_rdata_i != 32'd0) ? S_UL4 : S_URET;
          end else if (lp_q != 32'd0) begin
            st_q <= S_UL5;
          end else begin
            st_q <= (mem_rdata_i != 32'd0) ? S_UL6 : S_URET;
          end
        end
        S_UL4: st_q <= S_URET;
        S_UL5: st_q <= (ln_q != 32'd0) ? S_UL6 : S_URET;
        S_UL6: st_q <= S_URET;
        S_URET: begin
          case (ret_unlink_q)
            RU_MA:  st_q <= S_MA0;
            RU_MB:  st_q <= S_MB0;
            RU_MC1: begin arg_q <= nb_q; ret_unlink_q <= RU_MC2; st_q <= S_UL0; end
            RU_MC2: st_q <= S_MC0;
            default: st_q <= S_CV1;
          endcase
        end

        // Insertion at the head of a class list.
        S_PU0: st_q <= S_PU1;
        S_PU1: begin cls_q <= sfha_pkg::class_of(rsz); st_q <= S_PU2; end
        S_PU2: begin lp_q <= heads_q[cls_q]; st_q <= S_PU3; end
        S_PU3: st_q <= (lp_q != 32'd0) ? S_PU4 : S_PU5;
        S_PU4: st_q <= S_PU5;
        S_PU5: begin heads_q[cls_q] <= arg_q; st_q <= S_PRET; end
        S_PRET: begin
          if (ret_push_q == RP_MERGE) begin
            st_q <= S_MRET;
          end else begin
            res_q <= bp_q[15:0];
            st_q  <= S_DONE;
          end
        end

        // First-fit search from the request's class upward.
        S_FIND0: begin
          fcls_q <= {1'b0, sfha_pkg::class_of(32'(asize_q))};
          st_q   <= S_FD1;
        end
        S_FD1: begin
          if (fcls_q == (sfha_pkg::ClsW+1)'(sfha_pkg::NumClasses)) begin
            gb_q       <= (asize_q > chunk_i) ? asize_q : chunk_i;
            ret_grow_q <= GR_ALLOC;
            st_q       <= S_GROW0;
          end else begin
            walk_q <= heads_q[fcls_q[sfha_pkg::ClsW-1:0]];
            st_q   <= S_FD2;
          end
        end
        S_FD2: begin
          if (walk_q == 32'd0 || steps_q >= sfha_pkg::StepW'(sfha_pkg::HeapWords)) begin
            fcls_q <= fcls_q + 1'b1;
            st_q   <= S_FD1;
          end else begin
            st_q <= S_FD3;
          end
        end
        S_FD3: begin
          if (alu_res_i[32]) begin
            bp_q <= walk_q;
            st_q <= S_CV0;
          end else begin
            st_q <= S_FD3B;
          end
        end
        S_FD3B: st_q <= S_FD4;
        S_FD4: begin walk_q <= mem_rdata_i; steps_q <= steps_q + 1'b1; st_q <= S_FD2; end

        // Carving the allocation out of the chosen block.
        S_CV0: st_q <= S_CV0B;
        S_CV0B: begin
          sz_q <= rsz; arg_q <= bp_q; ret_unlink_q <= RU_CARVE; st_q <= S_UL0;
        end
        S_CV1: begin
          t_q  <= alu_res_i[31:0];
          st_q <= (alu_res_i[32] && alu_res_i[31:0] >= sfha_pkg::MinBlock) ? S_CV2 : S_CN0;
        end
        S_CV2: st_q <= S_CV3;
        S_CV3: begin end_q <= alu_res_i[31:0]; st_q <= S_CV4; end
        S_CV4: st_q <= S_CV5;
        S_CV5: st_q <= S_CV6;
        S_CV6: begin nb_q <= alu_res_i[31:0]; st_q <= S_CV7; end
        S_CV7: begin arg_q <= end_q; ret_push_q <= RP_CARVE; st_q <= S_PU0; end
        S_CN0: begin end_q <= alu_res_i[31:0]; st_q <= S_CN1; end
        S_CN1: st_q <= S_CN2;
        S_CN2: begin res_q <= bp_q[15:0]; st_q <= S_DONE; end

        // Free: tag checks, then mark free and coalesce.
        S_FR0: st_q <= S_FR1;
        S_FR1: begin
          t_q   <= mem_rdata_i;
          sz_q  <= rsz;
          end_q <= alu_res_i[31:0];
          if (mem_rdata_i[0] && rsz >= sfha_pkg::MinBlock && alu_res_i <= 33'(brk_q)) begin
            st_q <= S_FR2;
          end else begin
            st_q <= S_DONE;
          end
        end
        S_FR2: st_q <= S_FR3;
        S_FR3: st_q <= (mem_rdata_i == t_q) ? S_FR4 : S_DONE;
        S_FR4: st_q <= S_FR5;
        S_FR5: begin ret_merge_q <= MR_FREE; st_q <= S_MG0; end

        S_DONE: if (out_free_i) st_q <= S_IDLE;
        default: st_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_brk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    brk_q <= sfha_pkg::BrkW'(sfha_pkg::HeapBytes))
    else $error("heap break beyond heap size");
  a_mem_one_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_req_o.re && mem_req_o.we))
    else $error("read and write in the same step");
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idle_o |-> !mem_req_o.we)
    else $error("memory write while idle");
  a_cls_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fcls_q <= (sfha_pkg::ClsW+1)'(sfha_pkg::NumClasses))
    else $error("class search ran past the last class");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> idle_o)
    else $error("result handed off without returning to idle");
`endif

endmodule
`default_nettype wire

// ===== sv/segregated_fit_heap_allocator.sv =====
`default_nettype none
// One item at a time: a zero-size, reserved or rejected item goes from idle straight
// to done; other items run through the init, alloc or free steps. Allocation steps
// through FD2, FD3, FD3B and FD4 per free-list node and FD1 and FD2 per size class.
// The next item is accepted once the sequencer is back in idle; a pending result is held.
// rst_ni is asynchronous, active low: lists empty, heap uninitialized, chunk size 4096.
// Heap memory contents are not cleared by reset; init lays out the heap.
module segregated_fit_heap_allocator (
  input  logic       clk_i,
  input  logic       rst_ni,
  sfha_req_if.sink   req,
  sfha_rsp_if.source rsp,
  sfha_cfg_if.sink   cfg
);

  logic [sfha_pkg::ChunkW-1:0] chunk_q;
  logic                        rsp_valid_q;
  sfha_pkg::rsp_t              rsp_q;
  sfha_pkg::rsp_t              seq_rsp;
  sfha_pkg::req_t              seq_req;
  sfha_pkg::alu_op_t           alu_op;
  sfha_pkg::mem_req_t          mem_req;
  logic [32:0]                 alu_res;
  logic [31:0]                 mem_rdata;
  logic                        idle, done, start, out_free;

  // Chunk size register.
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_q <= sfha_pkg::ChunkReset;
    end else if (cfg.valid) begin
      chunk_q <= cfg.data;
    end
  end

  // Request intake.
  assign req.ready = idle;
  assign start     = req.valid && idle;
  assign seq_req   = '{req_type: req.req_type, request_size: req.request_size,
                       block_address: req.block_address};

  // Output register decouples the result from the next item's work.
  assign out_free = !rsp_valid_q || rsp.ready;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (done) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end
  always_ff @(posedge clk_i) begin
    if (done) rsp_q <= seq_rsp;
  end
  assign rsp.valid          = rsp_valid_q;
  assign rsp.result_address = rsp_q.result_address;
  assign rsp.status         = rsp_q.status;

  sfha_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .req_i       (seq_req),
    .chunk_i     (chunk_q),
    .out_free_i  (out_free),
    .idle_o      (idle),
    .done_o      (done),
    .rsp_o       (seq_rsp),
    .alu_op_o    (alu_op),
    .alu_res_i   (alu_res),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  sfha_alu u_alu (
    .op_i  (alu_op),
    .res_o (alu_res)
  );

  sfha_heap_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

endmodule
`default_nettype wire
